### src/hfc_pkg.sv
package hfc_pkg;

	typedef enum logic [1:0] {
		CMD_S2H       = 2'd0,
		CMD_H2S       = 2'd1,
		CMD_NEXT_UP   = 2'd2,
		CMD_NEXT_DOWN = 2'd3
	} cmd_t;

	typedef struct packed {
		cmd_t        command;
		logic [31:0] operand;
	} req_t;

	localparam logic [15:0] HALF_INF       = 16'h7C00;
	localparam logic [15:0] HALF_QNAN_BIT  = 16'h0200;
	localparam logic [15:0] HALF_MIN_SUB   = 16'h0001;
	localparam logic [15:0] HALF_MIN_SUB_N = 16'h8001;
	localparam logic [30:0] SGL_INF_MAG    = 31'h7F800000;
	localparam logic [30:0] SGL_OVF_MAG    = 31'h477FF000;
	localparam logic [30:0] SGL_TINY_MAG   = 31'h38800000;
	localparam logic [7:0]  EXP_BIAS_DIFF  = 8'd112;
	localparam logic [7:0]  SUB_EXP_BASE   = 8'd103;
	localparam logic [7:0]  SGL_EXP_ALL    = 8'hFF;
	localparam logic [4:0]  HALF_EXP_ALL   = 5'h1F;
	localparam logic [6:0]  TINY_SHIFT_TOP = 7'd126;
	localparam logic [6:0]  TINY_SHIFT_MAX = 7'd24;

endpackage

### src/hfc_s2h.sv
module hfc_s2h import hfc_pkg::*; (
	input  logic [31:0] sgl,
	output logic [15:0] hlf
);

	logic        sign;
	logic [30:0] mag;
	logic [7:0]  exp;
	logic [23:0] sig;
	logic [6:0]  eff;
	logic [6:0]  shift;
	logic [4:0]  sh;
	logic [4:0]  sh_m1;
	logic [23:0] q_full;
	logic [23:0] g_full;
	logic [23:0] sticky_mask;
	logic        tiny_up;
	logic [10:0] tiny_q;
	logic [4:0]  norm_exp;
	logic [14:0] norm_h;
	logic        norm_up;
	logic [14:0] norm_r;

	assign sign = sgl[31];
	assign mag  = sgl[30:0];
	assign exp  = mag[30:23];
	assign sig  = {(exp != 8'd0), mag[22:0]};

	// Subnormal result path: the significand is shifted right by 126 - exponent.
	assign eff         = (exp == 8'd0) ? 7'd1 : exp[6:0];
	assign shift       = TINY_SHIFT_TOP - eff;
	assign sh          = shift[4:0];
	assign sh_m1       = sh - 5'd1;
	assign q_full      = sig >> sh;
	assign g_full      = sig >> sh_m1;
	assign sticky_mask = (24'd1 << sh_m1) - 24'd1;
	assign tiny_up     = g_full[0] & ((|(sig & sticky_mask)) | q_full[0]);
	assign tiny_q      = q_full[10:0] + {10'd0, tiny_up};

	// Normal result path; a mantissa carry ripples into the exponent.
	assign norm_exp = 5'(exp - EXP_BIAS_DIFF);
	assign norm_h   = {norm_exp, mag[22:13]};
	assign norm_up  = mag[12] & ((|mag[11:0]) | norm_h[0]);
	assign norm_r   = norm_h + {14'd0, norm_up};

	always_comb begin
		priority if (mag > SGL_INF_MAG) begin
			hlf = {sign, 15'd0} | HALF_INF | HALF_QNAN_BIT;
		end else if (mag >= SGL_OVF_MAG) begin
			hlf = {sign, 15'd0} | HALF_INF;
		end else if (mag < SGL_TINY_MAG) begin
			if (shift > TINY_SHIFT_MAX) begin
				hlf = {sign, 15'd0};
			end else begin
				hlf = {sign, 4'd0, tiny_q};
			end
		end else begin
			hlf = {sign, norm_r};
		end
	end

endmodule

### src/hfc_h2s.sv
module hfc_h2s import hfc_pkg::*; (
	input  logic [15:0] hlf,
	output logic [31:0] sgl
);

	logic        sign;
	logic [4:0]  e;
	logic [9:0]  m;
	logic [3:0]  lead;
	logic [3:0]  shamt;
	logic [22:0] m23;
	logic [22:0] sub_mant;
	logic [7:0]  sub_exp;

	assign sign = hlf[15];
	assign e    = hlf[14:10];
	assign m    = hlf[9:0];

	// Position of the leading one of a subnormal mantissa.
	always_comb begin
		lead = 4'd0;
		for (int i = 0; i < 10; i++) begin
			if (m[i]) begin
				lead = 4'(i);
			end
		end
	end

	assign shamt    = 4'd10 - lead;
	assign m23      = {m, 13'd0};
	assign sub_mant = m23 << shamt;
	assign sub_exp  = {4'd0, lead} + SUB_EXP_BASE;

	always_comb begin
		priority if (e == 5'd0) begin
			if (m == 10'd0) begin
				sgl = {sign, 31'd0};
			end else begin
				sgl = {sign, sub_exp, sub_mant};
			end
		end else if (e == HALF_EXP_ALL) begin
			sgl = {sign, SGL_EXP_ALL, m, 13'd0};
		end else begin
			sgl = {sign, {3'd0, e} + EXP_BIAS_DIFF, m, 13'd0};
		end
	end

endmodule

### src/hfc_step.sv
module hfc_step import hfc_pkg::*; (
	input  logic [15:0] hlf,
	input  logic        down,
	output logic [15:0] res
);

	// A negative pattern moves toward zero when stepping up, away from it stepping down.
	logic decr;

	assign decr = hlf[15] ^ down;

	always_comb begin
		if (hlf[14:0] == 15'd0) begin
			res = down ? HALF_MIN_SUB_N : HALF_MIN_SUB;
		end else if (decr) begin
			res = hlf - 16'd1;
		end else begin
			res = hlf + 16'd1;
		end
	end

endmodule

### src/half_float_converter.sv
// Channel   Valid      Ready      Payload
// request   req_valid  req_ready  command, operand
// result    res_valid  res_ready  result
//
// One request per clock unless a stalled result holds req_ready low; res_valid
// rises once a taken request has passed through the request and result registers.
// The request register feeds the conversion logic, which feeds the result register.
// req_ready drops only when both registers are full and res_ready is low.
// Reset empties both registers; payload registers are not reset.
module half_float_converter import hfc_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic [1:0]  command,
	input  logic [31:0] operand,
	output logic        res_valid,
	input  logic        res_ready,
	output logic [31:0] result
);

	logic        valid_s1;
	req_t        req_s1;
	logic        res_valid_q;
	logic [31:0] result_q;
	logic        advance;
	logic [15:0] s2h_res;
	logic [31:0] h2s_res;
	logic [15:0] step_res;
	logic [31:0] conv;

	assign advance   = !res_valid_q || res_ready;
	assign req_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req_ready) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req_ready && req_valid) begin
			req_s1.command <= cmd_t'(command);
			req_s1.operand <= operand;
		end
	end

	hfc_s2h u_s2h (
		.sgl (req_s1.operand),
		.hlf (s2h_res)
	);

	hfc_h2s u_h2s (
		.hlf (req_s1.operand[15:0]),
		.sgl (h2s_res)
	);

	hfc_step u_step (
		.hlf  (req_s1.operand[15:0]),
		.down (req_s1.command == CMD_NEXT_DOWN),
		.res  (step_res)
	);

	always_comb begin
		unique case (req_s1.command)
			CMD_S2H:       conv = {16'd0, s2h_res};
			CMD_H2S:       conv = h2s_res;
			CMD_NEXT_UP,
			CMD_NEXT_DOWN: conv = {16'd0, step_res};
			default:       conv = {16'd0, step_res};
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			result_q <= conv;
		end
	end

	assign res_valid = res_valid_q;
	assign result    = result_q;

endmodule

### src/hfc_chk.sv
module hfc_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        res_valid,
	input logic        res_ready,
	input logic [31:0] result
);

	// A held result must not change or vanish.
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(result))
		else $error("result changed while stalled");

	// Back-pressure reaches the request side only from a stalled result.
	a_ready_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> res_valid && !res_ready)
		else $error("request stalled without a stalled result");

	// Once a taken request has passed the request register, a result is on offer.
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> ##1 res_valid)
		else $error("accepted request produced no result");

	// With the result side idle, nothing stalls the request side.
	a_idle_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> req_ready)
		else $error("request stalled with empty output");

endmodule

bind half_float_converter hfc_chk u_hfc_chk (.*);
